// File: rtl/kfc_pkg.sv
// Package with shared constants and command codes for the k-mer frequency counter.
`timescale 1ns / 1ps
package kfc_pkg;

  // Command codes
  localparam logic [1:0] CMD_FEED      = 2'd0;
  localparam logic [1:0] CMD_READ_HIST = 2'd1;
  localparam logic [1:0] CMD_READ_BASE = 2'd2;

  // Sequence characters that count as bases
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;

  // Base codes
  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  // Field widths fixed by the interface
  localparam int KLEN_W  = 4;
  localparam int FILL_W  = 4;
  localparam int CMD_W   = 2;
  localparam int SYM_W   = 8;
  localparam int IDX_W   = 16;
  localparam int CODE_W  = 16;
  localparam int START_W = 32;
  localparam int RDV_W   = 32;

endpackage

// File: rtl/kfc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module kfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the old contents when the same entry is written at that edge
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/kmer_frequency_counter_core.sv
// Top level of the DNA k-mer frequency counter: rolling code, base counters, histogram.
//
// Usage: one input channel (in_valid/in_ready) carries a command, a sequence byte and
// an index; one result channel (out_valid/out_ready) returns exactly one result per
// accepted transaction, in order. A feed command shifts A/C/G/T into a rolling code of
// k bases and, once k bases stand in a row, increments that k-mer's histogram bin and
// reports its code and start position. Read commands return a histogram bin or a base
// count, saturated to 32 bits. cfg_wr_en writes k (kmer_length).
// Pipeline: two register stages, the read stage and then the output register.
// Throughput: one transaction per cycle while out_ready stays high; the histogram lives
// in a RAM with registered read data, updated read-modify-write with a forwarding
// register for back-to-back hits on the same bin.
// Reset: counters, run and position clear at once; the histogram RAM is then swept to
// zero, one bin per cycle, and in_ready stays low until the sweep is done.
// Stall: while out_ready is low the result holds in the output register, one further
// transaction is taken into the read stage, and in_ready then falls until the result
// drains.
`timescale 1ns / 1ps
module kmer_frequency_counter_core #(
  parameter int MAX_K      = 8,
  parameter int COUNT_BITS = 32,
  parameter int POS_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_symbol,
  input  logic [15:0] in_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kmer_valid,
  output logic [15:0] out_kmer_code,
  output logic [31:0] out_kmer_start,
  output logic [31:0] out_read_value
);

  localparam int AW    = 2 * MAX_K;
  localparam int DEPTH = 1 << AW;
  localparam int KLW   = kfc_pkg::KLEN_W;
  localparam int FW    = kfc_pkg::FILL_W;
  localparam int IW    = kfc_pkg::IDX_W;
  localparam int RW    = kfc_pkg::RDV_W;

  // Configuration and run state
  logic [KLW-1:0]        klen_r;
  logic [AW-1:0]         code_r, code_nxt;
  logic [FW-1:0]         fill_r, fill_nxt;
  logic [POS_BITS-1:0]   pos_r;
  logic [COUNT_BITS-1:0] base_cnt_r [4];

  // Clearing sweep
  logic                  clr_active_r, clr_active_nxt;
  logic [AW-1:0]         clr_addr_r;

  // Read stage
  logic                  s1_valid_r;
  logic                  s1_hit_r;
  logic                  s1_rd_hist_r;
  logic [AW-1:0]         s1_addr_r;
  logic [AW-1:0]         s1_code_r;
  logic [POS_BITS-1:0]   s1_start_r;
  logic [RW-1:0]         s1_readv_r;
  logic                  s1_fwd_r;
  logic [COUNT_BITS-1:0] s1_fwd_data_r;

  // Output register
  logic                  out_valid_r;
  logic                  out_kmer_valid_r;
  logic [15:0]           out_kmer_code_r;
  logic [31:0]           out_kmer_start_r;
  logic [RW-1:0]         out_read_value_r;

  logic                  accept;
  logic                  s1_adv;
  logic                  is_feed;
  logic                  is_base;
  logic [1:0]            base_val;
  logic [KLW-1:0]        k_eff;
  logic [AW-1:0]         mask;
  logic                  hit;
  logic [POS_BITS-1:0]   start_pos;
  logic [AW+IW-1:0]      idx_ext;
  logic [AW-1:0]         idx_addr;
  logic                  idx_in_range;
  logic [AW-1:0]         rd_addr;
  logic [COUNT_BITS-1:0] base_sel_val;
  logic [COUNT_BITS+RW-1:0] base_ext;
  logic [RW-1:0]         base_sat;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [COUNT_BITS-1:0] mem_rdata;
  logic                  s1_wr;
  logic [COUNT_BITS-1:0] hist_val;
  logic [COUNT_BITS-1:0] hist_inc;
  logic [COUNT_BITS+RW-1:0] hist_ext;
  logic [RW-1:0]         hist_sat;
  logic [AW+15:0]        code_ext;
  logic [POS_BITS+31:0]  start_ext;

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !clr_active_r && (!s1_valid_r || s1_adv);
  assign accept   = in_valid && in_ready;
  assign is_feed  = (in_cmd == kfc_pkg::CMD_FEED);

  // Effective k: zero acts as one, anything above MAX_K as MAX_K
  always_comb begin
    if (klen_r == '0) begin
      k_eff = KLW'(1);
    end else if (klen_r > KLW'(MAX_K)) begin
      k_eff = KLW'(MAX_K);
    end else begin
      k_eff = klen_r;
    end
    for (int i = 0; i < AW; i++) begin
      mask[i] = (i < 2 * int'(k_eff));
    end
  end

  always_comb begin
    is_base  = 1'b1;
    base_val = kfc_pkg::BASE_A;
    case (in_symbol)
      kfc_pkg::CHAR_A: base_val = kfc_pkg::BASE_A;
      kfc_pkg::CHAR_C: base_val = kfc_pkg::BASE_C;
      kfc_pkg::CHAR_G: base_val = kfc_pkg::BASE_G;
      kfc_pkg::CHAR_T: base_val = kfc_pkg::BASE_T;
      default:         is_base  = 1'b0;
    endcase
  end

  always_comb begin
    if (is_base) begin
      code_nxt = ((code_r << 2) | AW'(base_val)) & mask;
      fill_nxt = (fill_r < FW'(k_eff)) ? fill_r + FW'(1) : FW'(k_eff);
    end else begin
      code_nxt = '0;
      fill_nxt = '0;
    end
    hit       = is_feed && is_base && (fill_nxt == FW'(k_eff));
    start_pos = pos_r - POS_BITS'(k_eff) + POS_BITS'(1);
  end

  // Histogram index: bins at or above 4^MAX_K read as zero
  assign idx_ext      = {{AW{1'b0}}, in_index};
  assign idx_addr     = idx_ext[AW-1:0];
  assign idx_in_range = ((idx_ext >> AW) == '0);
  assign rd_addr      = hit ? code_nxt : idx_addr;

  assign base_sel_val = base_cnt_r[in_index[1:0]];
  assign base_ext     = {{RW{1'b0}}, base_sel_val};
  assign base_sat     = ((base_ext >> RW) != '0) ? '1 : base_ext[RW-1:0];

  // k is written on cfg_wr_en; run state and base counters update on accepted feeds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r <= KLW'(2);
      code_r <= '0;
      fill_r <= '0;
      pos_r  <= '0;
      for (int b = 0; b < 4; b++) begin
        base_cnt_r[b] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        klen_r <= cfg_wr_data;
      end
      if (accept && is_feed) begin
        code_r <= code_nxt;
        fill_r <= fill_nxt;
        pos_r  <= pos_r + POS_BITS'(1);
        if (is_base && (base_cnt_r[base_val] != '1)) begin
          base_cnt_r[base_val] <= base_cnt_r[base_val] + COUNT_BITS'(1);
        end
      end
    end
  end

  // Clear the histogram one bin per cycle after reset
  assign clr_active_nxt = clr_active_r && (clr_addr_r != '1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_r + AW'(1);
    end
  end

  // Histogram read-modify-write
  assign s1_wr     = s1_valid_r && s1_adv && s1_hit_r;
  assign hist_val  = s1_fwd_r ? s1_fwd_data_r : mem_rdata;
  assign hist_inc  = (hist_val == '1) ? hist_val : hist_val + COUNT_BITS'(1);
  assign mem_we    = clr_active_r || s1_wr;
  assign mem_waddr = clr_active_r ? clr_addr_r : s1_addr_r;
  assign mem_wdata = clr_active_r ? '0 : hist_inc;

  assign hist_ext  = {{RW{1'b0}}, hist_val};
  assign hist_sat  = ((hist_ext >> RW) != '0) ? '1 : hist_ext[RW-1:0];

  kfc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_hist_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Capture the read stage; forward the bin written at this same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit_r      <= hit;
      s1_rd_hist_r  <= (in_cmd == kfc_pkg::CMD_READ_HIST) && idx_in_range;
      s1_addr_r     <= rd_addr;
      s1_code_r     <= hit ? code_nxt : '0;
      s1_start_r    <= hit ? start_pos : '0;
      s1_readv_r    <= ((in_cmd == kfc_pkg::CMD_READ_BASE) && (in_index[15:2] == '0)) ?
                       base_sat : '0;
      s1_fwd_r      <= s1_wr && (s1_addr_r == rd_addr);
      s1_fwd_data_r <= hist_inc;
    end
  end

  assign code_ext  = {16'b0, s1_code_r};
  assign start_ext = {32'b0, s1_start_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_kmer_valid_r <= s1_hit_r;
      out_kmer_code_r  <= code_ext[15:0];
      out_kmer_start_r <= start_ext[31:0];
      out_read_value_r <= s1_rd_hist_r ? hist_sat : s1_readv_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kmer_valid = out_kmer_valid_r;
  assign out_kmer_code  = out_kmer_code_r;
  assign out_kmer_start = out_kmer_start_r;
  assign out_read_value = out_read_value_r;

endmodule

// File: bench/kmer_frequency_counter_core_tb.sv
// Self-checking testbench for the k-mer frequency counter core.
`timescale 1ns / 1ps
module kmer_frequency_counter_core_tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int MAX_K        = 8;
  localparam int BIN_COUNT    = 1 << (2 * MAX_K);
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS  = 160;

  typedef struct packed {
    logic        kmer_valid;
    logic [15:0] code;
    logic [31:0] start;
    logic [31:0] read_value;
  } kmer_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [3:0]  cfg_wr_data = 4'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = kfc_pkg::CMD_FEED;
  logic [7:0]  in_symbol = 8'd0;
  logic [15:0] in_index = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kmer_valid;
  logic [15:0] out_kmer_code;
  logic [31:0] out_kmer_start;
  logic [31:0] out_read_value;

  // Mirror of the counter state
  bit [3:0]  klen = 4'd2;
  bit [15:0] roll_code = 16'd0;
  int unsigned run_len = 0;
  bit [31:0] next_pos = 32'd0;
  bit [31:0] bin_count [BIN_COUNT];
  bit [31:0] base_count [4];
  bit [15:0] seen_codes [$];

  kmer_result_t kmer_results_due [$];
  kmer_result_t head_due;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          idling = 1'b1;

  kmer_frequency_counter_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_symbol      (in_symbol),
    .in_index       (in_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kmer_valid (out_kmer_valid),
    .out_kmer_code  (out_kmer_code),
    .out_kmer_start (out_kmer_start),
    .out_read_value (out_read_value)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("kmer_frequency_counter_core_tb failed");
      $finish;
    end
  end

  function automatic int unsigned active_k();
    if (klen == 4'd0) return 1;
    if (klen > MAX_K) return MAX_K;
    return 32'(klen);
  endfunction

  function automatic bit [31:0] bump_sat(bit [31:0] cnt);
    return (cnt == '1) ? cnt : cnt + 32'd1;
  endfunction

  // Apply one transaction to the mirrored state and return the result it yields
  function automatic kmer_result_t advance_counter(logic [1:0] cmd, logic [7:0] sym,
                                                   logic [15:0] idx);
    kmer_result_t r;
    int unsigned  k;
    bit [31:0]    mask;
    bit [1:0]     b;
    bit           is_base;
    r = '0;
    b = kfc_pkg::BASE_A;
    is_base = 1'b1;
    case (cmd)
      kfc_pkg::CMD_FEED: begin
        k = active_k();
        mask = (32'd1 << (2 * k)) - 32'd1;
        case (sym)
          kfc_pkg::CHAR_A: b = kfc_pkg::BASE_A;
          kfc_pkg::CHAR_C: b = kfc_pkg::BASE_C;
          kfc_pkg::CHAR_G: b = kfc_pkg::BASE_G;
          kfc_pkg::CHAR_T: b = kfc_pkg::BASE_T;
          default: is_base = 1'b0;
        endcase
        if (is_base) begin
          roll_code = 16'(((32'(roll_code) << 2) | 32'(b)) & mask);
          base_count[b] = bump_sat(base_count[b]);
          run_len = (run_len < k) ? run_len + 1 : k;
          if (run_len == k) begin
            bin_count[roll_code] = bump_sat(bin_count[roll_code]);
            r.kmer_valid = 1'b1;
            r.code = roll_code;
            r.start = next_pos - 32'(k - 1);
            seen_codes = {seen_codes, roll_code};
            if (seen_codes.size() > 64) void'(seen_codes.pop_front());
          end
        end else begin
          roll_code = 16'd0;
          run_len = 0;
        end
        next_pos = next_pos + 32'd1;
      end
      // a 16-bit index always falls inside the histogram
      kfc_pkg::CMD_READ_HIST: r.read_value = bin_count[idx];
      kfc_pkg::CMD_READ_BASE: if (idx < 16'd4) r.read_value = base_count[idx[1:0]];
      default: ;
    endcase
    return r;
  endfunction

  // Receiver: random stall bursts while idling is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 14) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (kmer_results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: valid=%0d code=%h start=%0d value=%0d",
                   out_kmer_valid, out_kmer_code, out_kmer_start, out_read_value);
      end else begin
        head_due = kmer_results_due.pop_front();
        if (out_kmer_valid !== head_due.kmer_valid || out_kmer_code !== head_due.code ||
            out_kmer_start !== head_due.start ||
            out_read_value !== head_due.read_value) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"mismatch: exp valid=%0d code=%h start=%0d value=%0d",
                      " got valid=%0d code=%h start=%0d value=%0d"},
                     head_due.kmer_valid, head_due.code, head_due.start,
                     head_due.read_value, out_kmer_valid, out_kmer_code,
                     out_kmer_start, out_read_value);
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] sym,
                           input logic [15:0] idx);
    int unsigned  gap;
    kmer_result_t due;
    gap = 0;
    if (idling && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_symbol <= sym;
    in_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    due = advance_counter(cmd, sym, idx);
    kmer_results_due = {kmer_results_due, due};
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (kmer_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_kmer_length(input logic [3:0] len);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    klen = len;
  endtask

  // Empty counters after reset, out-of-range base index, unused command
  task automatic test_reset_state();
    send_item(kfc_pkg::CMD_READ_BASE, 8'h00, 16'd0);
    send_item(kfc_pkg::CMD_READ_BASE, 8'h00, 16'd4);
    send_item(kfc_pkg::CMD_READ_BASE, 8'h00, 16'hFFFF);
    send_item(kfc_pkg::CMD_READ_HIST, 8'h00, 16'd0);
    send_item(kfc_pkg::CMD_READ_HIST, 8'hFF, 16'hFFFF);
    send_item(CMD_UNUSED, 8'hFF, 16'hFFFF);
  endtask

  // Non-base bytes break the run; the byte after one counts normally
  task automatic test_feed_runs();
    send_item(kfc_pkg::CMD_FEED, kfc_pkg::CHAR_A, 16'd0);
    send_item(kfc_pkg::CMD_FEED, kfc_pkg::CHAR_C, 16'd0);
    send_item(kfc_pkg::CMD_FEED, kfc_pkg::CHAR_G, 16'd0);
    send_item(kfc_pkg::CMD_FEED, kfc_pkg::CHAR_T, 16'd0);
    send_item(kfc_pkg::CMD_FEED, 8'h00, 16'd0);
    send_item(kfc_pkg::CMD_FEED, kfc_pkg::CHAR_T, 16'd0);
    send_item(kfc_pkg::CMD_FEED, kfc_pkg::CHAR_T, 16'd0);
    send_item(kfc_pkg::CMD_FEED, 8'h61, 16'd0);
  endtask

  // Length extremes, out-of-range lengths and a change in the middle of a run
  task automatic test_length_settings();
    write_kmer_length(4'd1);
    send_item(kfc_pkg::CMD_FEED, kfc_pkg::CHAR_G, 16'd0);
    write_kmer_length(4'd0);
    send_item(kfc_pkg::CMD_FEED, kfc_pkg::CHAR_A, 16'd0);
    write_kmer_length(4'd15);
    repeat (8) send_item(kfc_pkg::CMD_FEED, kfc_pkg::CHAR_T, 16'd0);
    write_kmer_length(4'd3);
    send_item(kfc_pkg::CMD_FEED, kfc_pkg::CHAR_C, 16'd0);
    send_item(kfc_pkg::CMD_READ_HIST, 8'h00, 16'hFFFF);
  endtask

  task automatic test_random_stream();
    logic [3:0]  phase_len [10] = '{4'd5, 4'd1, 4'd8, 4'd0, 4'd3,
                                    4'd15, 4'd2, 4'd6, 4'd4, 4'd7};
    logic [1:0]  cmd;
    logic [7:0]  sym;
    logic [15:0] idx;
    int unsigned pick;
    for (int ph = 0; ph < 10; ph++) begin
      write_kmer_length(phase_len[ph]);
      // keep the last phase at full rate on both sides
      idling = (ph != 9);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        sym = 8'($urandom_range(0, 255));
        idx = 16'($urandom_range(0, 65535));
        if (pick < 70) begin
          cmd = kfc_pkg::CMD_FEED;
          if ($urandom_range(0, 99) < 92) begin
            case ($urandom_range(0, 3))
              0: sym = kfc_pkg::CHAR_A;
              1: sym = kfc_pkg::CHAR_C;
              2: sym = kfc_pkg::CHAR_G;
              default: sym = kfc_pkg::CHAR_T;
            endcase
          end
        end else if (pick < 85) begin
          cmd = kfc_pkg::CMD_READ_HIST;
          if (seen_codes.size() != 0 && $urandom_range(0, 1) == 1)
            idx = seen_codes[$urandom_range(0, seen_codes.size() - 1)];
        end else if (pick < 95) begin
          cmd = kfc_pkg::CMD_READ_BASE;
          if ($urandom_range(0, 4) != 4) idx = 16'($urandom_range(0, 3));
        end else begin
          cmd = CMD_UNUSED;
        end
        send_item(cmd, sym, idx);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_feed_runs();
    test_length_settings();
    test_random_stream();
    settle();
    if (fail_count == 0) begin
      $display("kmer_frequency_counter_core_tb passed");
    end else begin
      $display("kmer_frequency_counter_core_tb failed");
    end
    $finish;
  end

endmodule
